// ===== hw/rtl/sia_pkg.sv =====
// ----------------------------------------------------------------------------
// sia_pkg
// Types and constants shared by the sorted insertion array and its cells.
// ----------------------------------------------------------------------------
package sia_pkg;

   localparam int VALUE_W = 32;
   localparam int CNT_W   = 5;
   localparam int POS_W   = 4;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOW_DUP = 8'd1;

   localparam logic [CNT_W-1:0] CAPACITY_RESET  = 5'd16;
   localparam logic             ALLOW_DUP_RESET = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_DUP      = 2'd2
   } status_type;

   // handed from one cell to the next
   typedef struct packed {
      logic                      after;
      logic signed [VALUE_W-1:0] value;
   } link_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [CNT_W-1:0] capacity;
      logic             allow_dup;
   } cfg_type;

endpackage

// ===== hw/rtl/sia_if.sv =====
// ----------------------------------------------------------------------------
// sia channel interfaces
// Valid/ready channels for values in, results out and register writes.
// ----------------------------------------------------------------------------
interface sia_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [sia_pkg::VALUE_W-1:0] new_value;

   modport source (output valid, output new_value, input ready);
   modport sink   (input valid, input new_value, output ready);
endinterface

interface sia_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sia_pkg::STAT_W-1:0]  status;
   logic [sia_pkg::POS_W-1:0]   position;
   logic [sia_pkg::CNT_W-1:0]   entry_count;

   modport source (output valid, output status, output position, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input position, input entry_count,
                   output ready);
endinterface

interface sia_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sia_pkg::CSR_IDX_W-1:0]     index;
   logic [sia_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/sia_cell.sv =====
// ----------------------------------------------------------------------------
// sia_cell
// One slot of the sorted row: compares its entry with the offered value and
// takes either its left neighbor's entry or the new value on an insert.
// ----------------------------------------------------------------------------
module sia_cell (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic                               held,
   input  logic signed [sia_pkg::VALUE_W-1:0] new_value,
   input  sia_pkg::link_type                  prev,
   output sia_pkg::link_type                  next,
   output logic                               equal
);

   logic signed [sia_pkg::VALUE_W-1:0] entry_ff;
   logic signed [sia_pkg::VALUE_W-1:0] entry_in;
   logic                               greater;

   always_comb begin
      greater    = entry_ff > new_value;
      next.after = !held || greater;
      next.value = entry_ff;
      equal      = entry_ff == new_value;
      // left neighbor past the gap: shift up, else this is the gap
      entry_in   = prev.after ? prev.value : new_value;
   end

   always_ff @(posedge clock) begin
      if (wr_en && next.after) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== hw/rtl/sia_encode.sv =====
// ----------------------------------------------------------------------------
// sia_encode
// One-hot to binary index encoder over the cell row.
// ----------------------------------------------------------------------------
module sia_encode #(
   parameter int N = 16,
   parameter int W = 4
) (
   input  logic [N-1:0] hot,
   output logic [W-1:0] idx
);

   always_comb begin
      idx = '0;
      for (int i = 0; i < N; i++) begin
         if (hot[i]) begin
            idx = idx | W'(i);
         end
      end
   end

endmodule

// ===== hw/rtl/sia_csr.sv =====
// ----------------------------------------------------------------------------
// sia_csr
// Configuration registers: capacity limit and duplicate policy.
// ----------------------------------------------------------------------------
module sia_csr (
   input  logic              clock,
   input  logic              reset,
   sia_csr_if.sink           csr_chan,
   output sia_pkg::cfg_type  cfg
);

   logic [sia_pkg::CNT_W-1:0] capacity_ff;
   logic [sia_pkg::CNT_W-1:0] capacity_in;
   logic                      allow_dup_ff;
   logic                      allow_dup_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      capacity_in  = capacity_ff;
      allow_dup_in = allow_dup_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            sia_pkg::CSR_CAPACITY:  capacity_in  = csr_chan.data[sia_pkg::CNT_W-1:0];
            sia_pkg::CSR_ALLOW_DUP: allow_dup_in = csr_chan.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= sia_pkg::CAPACITY_RESET;
         allow_dup_ff <= sia_pkg::ALLOW_DUP_RESET;
      end else begin
         capacity_ff  <= capacity_in;
         allow_dup_ff <= allow_dup_in;
      end
   end

   assign cfg.capacity  = capacity_ff;
   assign cfg.allow_dup = allow_dup_ff;

endmodule

// ===== hw/rtl/sorted_insert_array.sv =====
// ----------------------------------------------------------------------------
// sorted_insert_array
// Keeps a bounded list of signed values in ascending order in a row of
// compare-and-shift cells; reports status, position and count per value.
// ----------------------------------------------------------------------------
//
//   channel    dir   payload                              role
//   req_chan   in    new_value                            value to insert
//   rsp_chan   out   status, position, entry_count        one result per item
//   csr_chan   in    index, data                          register write
//
// one item per cycle: every cell compares against the value at once and the
// row shifts at the accepting edge; the result goes to an output register
// while req_chan stays ready if that register is empty or being taken.
// a stalled result holds req_chan off until it is taken.
// reset clears the count and loads the register defaults; cell contents are
// not cleared, only entries below the count are ever looked at.
// ----------------------------------------------------------------------------
module sorted_insert_array #(
   parameter int LIST_DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   sia_req_if.sink   req_chan,
   sia_rsp_if.source rsp_chan,
   sia_csr_if.sink   csr_chan
);

   localparam int IDX_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   // the count register cannot go past its own range
   localparam int DEPTH_CAP = (LIST_DEPTH < 31) ? LIST_DEPTH : 31;
   localparam logic [sia_pkg::CNT_W-1:0] DEPTH_LIM = sia_pkg::CNT_W'(DEPTH_CAP);

   sia_pkg::cfg_type  cfg;
   sia_pkg::link_type chain [LIST_DEPTH+1];

   logic [LIST_DEPTH-1:0] held;
   logic [LIST_DEPTH-1:0] equal;
   logic [LIST_DEPTH:0]   after_ext;
   logic [LIST_DEPTH-1:0] ins_hot;
   logic [LIST_DEPTH-1:0] dup_hot;
   logic [IDX_W-1:0]      ins_idx;
   logic [IDX_W-1:0]      dup_idx;

   logic [sia_pkg::CNT_W-1:0] count_ff;
   logic [sia_pkg::CNT_W-1:0] count_in;
   logic [sia_pkg::CNT_W-1:0] cap_eff;
   logic                      full;
   logic                      is_dup;
   logic                      accept;
   logic                      wr_en;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   sia_pkg::status_type         status_ff;
   sia_pkg::status_type         status_in;
   logic [sia_pkg::POS_W-1:0]   position_ff;
   logic [sia_pkg::POS_W-1:0]   position_in;
   logic [sia_pkg::CNT_W-1:0]   entry_count_ff;
   logic [sia_pkg::CNT_W-1:0]   entry_count_in;

   sia_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   assign chain[0].after = 1'b0;
   assign chain[0].value = '0;

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      if (i < DEPTH_CAP) begin : g_live
         assign held[i] = count_ff > sia_pkg::CNT_W'(i);
      end else begin : g_dead
         assign held[i] = 1'b0;
      end

      sia_cell u_cell (
         .clock     (clock),
         .wr_en     (wr_en),
         .held      (held[i]),
         .new_value (req_chan.new_value),
         .prev      (chain[i]),
         .next      (chain[i+1]),
         .equal     (equal[i])
      );
   end

   always_comb begin
      after_ext[LIST_DEPTH] = 1'b1;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         after_ext[i] = chain[i+1].after;
      end
      for (int i = 0; i < LIST_DEPTH; i++) begin
         ins_hot[i] = after_ext[i] & ~chain[i].after;
         // last equal entry sits right below the gap
         dup_hot[i] = ~after_ext[i] & after_ext[i+1] & equal[i];
      end
   end

   sia_encode #(.N(LIST_DEPTH), .W(IDX_W)) u_ins_enc (
      .hot (ins_hot),
      .idx (ins_idx)
   );

   sia_encode #(.N(LIST_DEPTH), .W(IDX_W)) u_dup_enc (
      .hot (dup_hot),
      .idx (dup_idx)
   );

   assign cap_eff         = (cfg.capacity > DEPTH_LIM) ? DEPTH_LIM : cfg.capacity;
   assign full            = count_ff >= cap_eff;
   assign is_dup          = !cfg.allow_dup && (|dup_hot);
   assign req_chan.ready  = !rsp_valid_ff || rsp_chan.ready;
   assign accept          = req_chan.valid && req_chan.ready;
   assign wr_en           = accept && !full && !is_dup;

   always_comb begin
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;
      status_in      = status_ff;
      position_in    = position_ff;
      entry_count_in = entry_count_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (full) begin
            status_in      = sia_pkg::ST_FULL;
            position_in    = '0;
            entry_count_in = count_ff;
         end else if (is_dup) begin
            status_in      = sia_pkg::ST_DUP;
            position_in    = sia_pkg::POS_W'(dup_idx);
            entry_count_in = count_ff;
         end else begin
            count_in       = count_ff + 1'b1;
            status_in      = sia_pkg::ST_INSERTED;
            position_in    = sia_pkg::POS_W'(ins_idx);
            entry_count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      position_ff    <= position_in;
      entry_count_ff <= entry_count_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.position    = position_ff;
   assign rsp_chan.entry_count = entry_count_ff;

endmodule
